FILE: rtl/midi_event_stream_parser_top_macros.svh
// assertion macros for the event parser checker
`ifndef MIDI_EVENT_STREAM_PARSER_TOP_MACROS_SVH
`define MIDI_EVENT_STREAM_PARSER_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define MESP_ASSERT_IMPL(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// plain check on every clock edge
`define MESP_ASSERT_ALWAYS(label, clk, cond, msg) \
   label: assert property (@(posedge clk) (cond)) else $error(msg);
`endif

FILE: rtl/mesp_pkg.sv
// ----------------------------------------------------------------------------
// mesp_pkg
// types and constants shared by the event stream parser
// ----------------------------------------------------------------------------
package mesp_pkg;

   // result kinds
   localparam logic [3:0] KIND_NOTEON    = 4'd0;
   localparam logic [3:0] KIND_NOTEOFF   = 4'd1;
   localparam logic [3:0] KIND_VOL       = 4'd2;
   localparam logic [3:0] KIND_PAN       = 4'd3;
   localparam logic [3:0] KIND_EXPR      = 4'd4;
   localparam logic [3:0] KIND_LOOPSTART = 4'd5;
   localparam logic [3:0] KIND_LOOPEND   = 4'd6;
   localparam logic [3:0] KIND_CTRL      = 4'd7;
   localparam logic [3:0] KIND_PROG      = 4'd8;
   localparam logic [3:0] KIND_BEND      = 4'd9;
   localparam logic [3:0] KIND_TEMPO     = 4'd10;
   localparam logic [3:0] KIND_TIMESIG   = 4'd11;
   localparam logic [3:0] KIND_EOT       = 4'd12;
   localparam logic [3:0] KIND_META      = 4'd13;
   localparam logic [3:0] KIND_STOP      = 4'd14;
   localparam logic [3:0] KIND_TRUNC     = 4'd15;

   // status and meta codes
   localparam logic [7:0] STAT_META     = 8'hFF;
   localparam logic [7:0] META_EOT      = 8'h2F;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [7:0] META_TIMESIG  = 8'h58;
   localparam logic [3:0] HI_NOTEOFF    = 4'h8;
   localparam logic [3:0] HI_NOTEON     = 4'h9;
   localparam logic [3:0] HI_CTRL       = 4'hB;
   localparam logic [3:0] HI_PROG       = 4'hC;
   localparam logic [3:0] HI_BEND       = 4'hE;
   localparam logic [7:0] CC_VOLUME     = 8'd7;
   localparam logic [7:0] CC_PAN        = 8'd10;
   localparam logic [7:0] CC_EXPR       = 8'd11;
   localparam logic [7:0] CC_LOOP       = 8'd99;
   localparam logic [7:0] LOOP_START    = 8'd20;
   localparam logic [7:0] LOOP_END      = 8'd30;

   // one result record
   typedef struct packed {
      logic [3:0]  event_kind;
      logic [3:0]  midi_channel;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [23:0] tempo_value;
      logic [27:0] delta_ticks;
      logic [31:0] event_time;
      logic [31:0] event_start;
      logic [31:0] event_length;
      logic        parsing_stopped;
   } record_type;

endpackage

FILE: rtl/mesp_core.sv
// ----------------------------------------------------------------------------
// mesp_core
// per-byte parse state update and record build, one byte per cycle while step is high
// ----------------------------------------------------------------------------
module mesp_core import mesp_pkg::*; #(
   parameter int VARLEN_MAX_BYTES = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,          // one byte taken this cycle
   input  logic [7:0] stream_byte,
   input  logic       final_byte,
   output logic       emit,          // a record results from this byte
   output record_type rec,
   output logic       halted
);

   typedef enum logic [3:0] {
      PH_START, PH_SAW_FF, PH_SAW_FF2F, PH_DELTA, PH_STATUS,
      PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN, PH_META_BODY
   } phase_type;

   localparam logic [2:0] VMAX = 3'(VARLEN_MAX_BYTES);

   phase_type   phase_ff, phase_in;
   logic [7:0]  rs_ff, rs_in;
   logic [27:0] dacc_ff, dacc_in;
   logic [2:0]  dcnt_ff, dcnt_in;
   logic [31:0] atime_ff, atime_in;
   logic [7:0]  held_ff, held_in;
   logic [7:0]  mtype_ff, mtype_in;
   logic [27:0] mlen_ff, mlen_in;
   logic [27:0] mseen_ff, mseen_in;
   logic [23:0] mpay_ff, mpay_in;
   logic [31:0] pos_ff, start_ff, start_in;
   logic        halted_ff, halted_in;

   assign halted = halted_ff;

   logic [31:0] len;
   logic [27:0] dshift;
   logic [2:0]  dcnt_p1;
   logic        dlast;
   logic [27:0] mlen_next;
   logic [27:0] mseen_p1;

   assign start_in = (phase_ff == PH_START) ? pos_ff : start_ff;
   assign len      = pos_ff + 32'd1 - start_in;
   assign dshift   = {dacc_ff[20:0], stream_byte[6:0]};
   assign dcnt_p1  = dcnt_ff + 3'd1;
   assign dlast    = !stream_byte[7] || (dcnt_p1 >= VMAX);
   assign mlen_next = {mlen_ff[20:0], stream_byte[6:0]};
   assign mseen_p1 = mseen_ff + 28'd1;

   // record helper state
   logic       put;
   record_type r;

   always_comb begin
      logic [7:0]  rs_eff;
      logic [3:0]  hi;
      logic        real_st;
      logic [3:0]  k2;
      logic [27:0] mlen_use;
      logic        do_status;
      logic        do_meta;
      phase_in  = phase_ff;
      rs_in     = rs_ff;
      dacc_in   = dacc_ff;
      dcnt_in   = dcnt_ff;
      atime_in  = atime_ff;
      held_in   = held_ff;
      mtype_in  = mtype_ff;
      mlen_in   = mlen_ff;
      mseen_in  = mseen_ff;
      mpay_in   = mpay_ff;
      halted_in = halted_ff;
      put       = 1'b0;
      r         = '0;
      do_status = 1'b0;
      do_meta   = 1'b0;
      mlen_use  = mlen_ff;
      rs_eff    = rs_ff;
      hi        = '0;
      real_st   = stream_byte[7];
      k2        = KIND_CTRL;

      // phase step
      unique case (phase_ff)
         PH_START: begin
            if (stream_byte == STAT_META && VARLEN_MAX_BYTES >= 2) begin
               dacc_in  = 28'h7F;
               dcnt_in  = 3'd1;
               phase_in = PH_SAW_FF;
            end else begin
               dacc_in  = {21'd0, stream_byte[6:0]};
               dcnt_in  = 3'd1;
               if (!stream_byte[7] || 3'd1 >= VMAX) begin
                  atime_in = atime_ff + {4'd0, dacc_in};
                  phase_in = PH_STATUS;
               end else phase_in = PH_DELTA;
            end
         end
         PH_SAW_FF: begin
            if (stream_byte == META_EOT) begin
               dacc_in  = 28'h3FAF;
               dcnt_in  = 3'd2;
               phase_in = PH_SAW_FF2F;
            end else begin
               dacc_in = dshift;
               dcnt_in = dcnt_p1;
               if (dlast) begin
                  atime_in = atime_ff + {4'd0, dshift};
                  phase_in = PH_STATUS;
               end else phase_in = PH_DELTA;
            end
         end
         PH_SAW_FF2F: begin
            if (stream_byte == 8'd0) begin
               put = 1'b1;
               r.event_kind = KIND_EOT;
               r.midi_channel = rs_ff[3:0];
               r.parsing_stopped = 1'b1;
            end else begin
               atime_in  = atime_ff + {4'd0, dacc_ff};
               do_status = 1'b1;
            end
         end
         PH_DELTA: begin
            dacc_in = dshift;
            dcnt_in = dcnt_p1;
            if (dlast) begin
               atime_in = atime_ff + {4'd0, dshift};
               phase_in = PH_STATUS;
            end
         end
         PH_STATUS: do_status = 1'b1;
         PH_DATA1: begin
            if (rs_ff[7:4] == HI_PROG) begin
               put = 1'b1;
               r.event_kind = KIND_PROG;
               r.midi_channel = rs_ff[3:0];
               r.first_data = stream_byte;
               r.delta_ticks = dacc_ff;
            end else begin
               held_in  = stream_byte;
               phase_in = PH_DATA2;
            end
         end
         PH_DATA2: begin
            if (rs_ff[7:4] == HI_NOTEOFF) k2 = KIND_NOTEOFF;
            else if (rs_ff[7:4] == HI_NOTEON)
               k2 = (stream_byte != 8'd0) ? KIND_NOTEON : KIND_NOTEOFF;
            else if (rs_ff[7:4] == HI_BEND) k2 = KIND_BEND;
            else if (held_ff == CC_VOLUME) k2 = KIND_VOL;
            else if (held_ff == CC_PAN) k2 = KIND_PAN;
            else if (held_ff == CC_EXPR) k2 = KIND_EXPR;
            else if (held_ff == CC_LOOP && stream_byte == LOOP_START) k2 = KIND_LOOPSTART;
            else if (held_ff == CC_LOOP && stream_byte == LOOP_END) k2 = KIND_LOOPEND;
            else k2 = KIND_CTRL;
            put = 1'b1;
            r.event_kind = k2;
            r.midi_channel = rs_ff[3:0];
            r.first_data = held_ff;
            r.second_data = stream_byte;
            r.delta_ticks = dacc_ff;
         end
         PH_META_TYPE: begin
            mtype_in = stream_byte;
            mlen_in  = '0;
            mseen_in = '0;
            mpay_in  = '0;
            dcnt_in  = '0;
            phase_in = PH_META_LEN;
         end
         PH_META_LEN: begin
            mlen_in = mlen_next;
            dcnt_in = dcnt_p1;
            if (dlast) begin
               if (mlen_next == 28'd0) begin
                  do_meta  = 1'b1;
                  mlen_use = mlen_next;
               end else phase_in = PH_META_BODY;
            end
         end
         PH_META_BODY: begin
            unique case (mseen_ff[1:0])
               2'd0: if (mseen_ff < 28'd3) mpay_in[23:16] = stream_byte;
               2'd1: if (mseen_ff < 28'd3) mpay_in[15:8] = stream_byte;
               2'd2: if (mseen_ff < 28'd3) mpay_in[7:0] = stream_byte;
               default: ;
            endcase
            mseen_in = mseen_p1;
            if (mseen_p1 >= mlen_ff) do_meta = 1'b1;
         end
         default: phase_in = PH_START;
      endcase

      // status byte handling
      if (do_status) begin
         if (real_st) rs_in = stream_byte;
         rs_eff = rs_in;
         hi     = rs_eff[7:4];
         if (!real_st && rs_ff == 8'd0) begin
            put = 1'b1;
            r.event_kind = KIND_STOP;
            r.delta_ticks = dacc_ff;
            r.parsing_stopped = 1'b1;
            r.event_length = len - 32'd1;
         end else if (hi == HI_NOTEOFF || hi == HI_NOTEON || hi == HI_CTRL
                      || hi == HI_BEND) begin
            if (real_st) phase_in = PH_DATA1;
            else begin
               held_in  = stream_byte;
               phase_in = PH_DATA2;
            end
         end else if (hi == HI_PROG) begin
            if (real_st) phase_in = PH_DATA1;
            else begin
               put = 1'b1;
               r.event_kind = KIND_PROG;
               r.midi_channel = rs_eff[3:0];
               r.first_data = stream_byte;
               r.delta_ticks = dacc_ff;
            end
         end else if (rs_eff == STAT_META) begin
            if (real_st) phase_in = PH_META_TYPE;
            else begin
               mtype_in = stream_byte;
               mlen_in  = '0;
               mseen_in = '0;
               mpay_in  = '0;
               dcnt_in  = '0;
               phase_in = PH_META_LEN;
            end
         end else begin
            put = 1'b1;
            r.event_kind = KIND_STOP;
            r.midi_channel = rs_eff[3:0];
            r.delta_ticks = dacc_ff;
            r.parsing_stopped = 1'b1;
            r.event_length = real_st ? len : len - 32'd1;
         end
      end

      // meta completion
      if (do_meta) begin
         put = 1'b1;
         r.midi_channel = rs_ff[3:0];
         r.delta_ticks = dacc_ff;
         if (mtype_ff == META_TEMPO) begin
            r.event_kind = KIND_TEMPO;
            r.tempo_value = mpay_in;
         end else if (mtype_ff == META_TIMESIG) begin
            r.event_kind = KIND_TIMESIG;
            r.first_data = mpay_in[23:16];
            r.second_data = mpay_in[15:8];
         end else if (mtype_ff == META_EOT) begin
            r.event_kind = KIND_EOT;
            r.parsing_stopped = 1'b1;
         end else begin
            r.event_kind = KIND_META;
            r.first_data = mtype_ff;
         end
         if (mlen_use != 28'd0) r.event_length = len;
      end

      // length of completed records
      if (put && r.event_kind != KIND_STOP) r.event_length = len;
      if (put) phase_in = PH_START;

      // final byte: stop flag or truncation record
      if (final_byte) begin
         if (put) r.parsing_stopped = 1'b1;
         else begin
            put = 1'b1;
            r = '0;
            r.event_kind = KIND_TRUNC;
            r.delta_ticks = dacc_in;
            r.event_length = len;
            r.parsing_stopped = 1'b1;
            phase_in = PH_START;
         end
      end
      if (put && r.parsing_stopped) halted_in = 1'b1;
      r.event_time  = atime_in;
      r.event_start = start_in;
   end

   assign emit = step && put;
   assign rec  = r;

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         rs_ff     <= '0;
         dacc_ff   <= '0;
         dcnt_ff   <= '0;
         atime_ff  <= '0;
         held_ff   <= '0;
         mtype_ff  <= '0;
         mlen_ff   <= '0;
         mseen_ff  <= '0;
         mpay_ff   <= '0;
         pos_ff    <= '0;
         start_ff  <= '0;
         halted_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         rs_ff     <= rs_in;
         dacc_ff   <= dacc_in;
         dcnt_ff   <= dcnt_in;
         atime_ff  <= atime_in;
         held_ff   <= held_in;
         mtype_ff  <= mtype_in;
         mlen_ff   <= mlen_in;
         mseen_ff  <= mseen_in;
         mpay_ff   <= mpay_in;
         pos_ff    <= pos_ff + 32'd1;
         start_ff  <= start_in;
         halted_ff <= halted_in;
      end
   end

endmodule

FILE: rtl/midi_event_stream_parser_top.sv
// ----------------------------------------------------------------------------
// midi_event_stream_parser_top
// track event byte parser producing one classified record per event
// ----------------------------------------------------------------------------
// Bytes enter on the req_ channel, one per transfer, with tuser marking the
// last byte of the file. Each transfer updates the parse state in the same
// cycle; a byte that completes an event loads the result register, or the skid
// stage while a stalled record holds that register, and rsp_ shows the result
// register. One byte is taken every cycle while req_tready is high: the result
// register is followed by a skid stage, so req_tready stays high while a record
// waits on a stalled receiver, and drops only once both stages hold records.
// Records carrying parsing_stopped end the stream: later bytes are taken
// and dropped with no record until reset. Reset (synchronous, active high)
// clears the phase, running status, time and position counters and empties
// both output stages.
// ----------------------------------------------------------------------------
module midi_event_stream_parser_top import mesp_pkg::*; #(
   parameter int VARLEN_MAX_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] stream_byte
   input  logic         req_tuser,   // [0] final_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] event_kind, [7:4] midi_channel, [15:8] first_data,
   // [23:16] second_data, [47:24] tempo_value, [75:48] delta_ticks,
   // [107:76] event_time, [139:108] event_start, [171:140] event_length,
   // [172] parsing_stopped, [175:173] zero
   output logic [175:0] rsp_tdata
);

   logic       step;
   logic       emit;
   logic       halted;
   record_type rec;
   record_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;

   assign req_tready = !skid_valid_ff;
   assign step       = req_tvalid && req_tready;

   mesp_core #(.VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step && !halted),
      .stream_byte (req_tdata),
      .final_byte  (req_tuser),
      .emit        (emit),
      .rec         (rec),
      .halted      (halted)
   );

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || rsp_tready) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= emit;
               skid_ff       <= rec;
            end else begin
               out_valid_ff <= emit;
               out_ff       <= rec;
            end
         end else if (emit) begin
            skid_valid_ff <= 1'b1;
            skid_ff       <= rec;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_ff.parsing_stopped, out_ff.event_length,
                        out_ff.event_start, out_ff.event_time, out_ff.delta_ticks,
                        out_ff.tempo_value, out_ff.second_data, out_ff.first_data,
                        out_ff.midi_channel, out_ff.event_kind};

endmodule

FILE: rtl/mesp_checker.sv
// ----------------------------------------------------------------------------
// mesp_checker
// port-level checks on the event parser
// ----------------------------------------------------------------------------
`include "midi_event_stream_parser_top_macros.svh"

module mesp_checker import mesp_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [175:0] rsp_tdata
);

   // a stalled record holds
   `MESP_ASSERT_IMPL(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "record changed while stalled")
   // no record right after reset
   `MESP_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "record after reset")
   // ready only drops while a record waits
   `MESP_ASSERT_IMPL(a_ready_drop, clock, reset, !req_tready |-> rsp_tvalid, "stall with no record")
   // truncation records always stop parsing
   `MESP_ASSERT_IMPL(a_trunc_stop, clock, reset, (rsp_tvalid && rsp_tdata[3:0] == KIND_TRUNC) |-> rsp_tdata[172], "truncation without stop")

endmodule

bind midi_event_stream_parser_top mesp_checker u_mesp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: verif/midi_event_stream_parser_checker.sv
// ----------------------------------------------------------------------------
// midi_event_stream_parser_checker
// watches both streams of the event parser, predicts and compares records
// ----------------------------------------------------------------------------
// Every accepted byte runs through a local copy of the parse machine. Each
// completed event becomes an expected record, and each record transfer on
// rsp_ is compared field by field with the oldest expected record.
// ----------------------------------------------------------------------------
module midi_event_stream_parser_checker import mesp_pkg::*; #(
   parameter int VARLEN_MAX_BYTES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] stream_byte
   input  logic         req_tuser,   // [0] final_byte
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [175:0] rsp_tdata,   // kind, channel, data, tempo, delta, time, start, length, stop
   output int           error_count,
   output int           pending,
   output int           record_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      PH_START, PH_SAW_FF, PH_SAW_FF2F, PH_DELTA, PH_STATUS,
      PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN, PH_META_BODY
   } phase_type;

   phase_type   phase;
   logic [7:0]  run_status, held_data, meta_kind;
   logic [27:0] delta_acc, meta_len, meta_seen;
   logic [2:0]  varlen_count;
   logic [31:0] abs_time, byte_pos, start_pos;
   logic [23:0] meta_data;
   logic        halted;

   // record being built by the current byte
   logic        rec_valid;
   logic [3:0]  rec_kind, rec_chan;
   logic [7:0]  rec_d1, rec_d2;
   logic [23:0] rec_tempo;
   logic [27:0] rec_delta;
   logic [31:0] rec_len;
   logic        rec_stop;

   record_type  expected_records[$];

   assign pending = expected_records.size();

   task automatic close_event(input logic [3:0] kind, input logic [3:0] chan,
                              input logic [7:0] d1, input logic [7:0] d2,
                              input logic [23:0] tempo, input logic [27:0] delta,
                              input logic [31:0] len, input logic stop);
      rec_valid = 1'b1; rec_kind = kind; rec_chan = chan; rec_d1 = d1; rec_d2 = d2;
      rec_tempo = tempo; rec_delta = delta; rec_len = len; rec_stop = stop;
      if (stop) halted = 1'b1;
      phase = PH_START;
   endtask

   task automatic channel_done(input logic [3:0] kind, input logic [7:0] d1,
                               input logic [7:0] d2, input logic [23:0] tempo,
                               input logic [31:0] len);
      close_event(kind, run_status[3:0], d1, d2, tempo, delta_acc, len, 1'b0);
   endtask

   task automatic delta_step(input logic [7:0] b);
      delta_acc = (delta_acc << 7) | b[6:0];
      varlen_count++;
      if (!b[7] || varlen_count >= VARLEN_MAX_BYTES) begin
         abs_time += 32'(delta_acc);
         phase = PH_STATUS;
      end else begin
         phase = PH_DELTA;
      end
   endtask

   task automatic meta_close(input logic [31:0] len);
      if (meta_kind == META_TEMPO)
         channel_done(KIND_TEMPO, 8'd0, 8'd0, meta_data, len);
      else if (meta_kind == META_TIMESIG)
         channel_done(KIND_TIMESIG, meta_data[23:16], meta_data[15:8], 24'd0, len);
      else if (meta_kind == META_EOT)
         close_event(KIND_EOT, run_status[3:0], 8'd0, 8'd0, 24'd0, delta_acc, len, 1'b1);
      else
         channel_done(KIND_META, meta_kind, 8'd0, 24'd0, len);
   endtask

   task automatic meta_open(input logic [7:0] b);
      meta_kind = b; meta_len = '0; meta_seen = '0; meta_data = '0;
      varlen_count = '0;
      phase = PH_META_LEN;
   endtask

   task automatic status_position(input logic [7:0] b, input logic [31:0] len);
      logic real_status;
      logic [3:0] hi;
      real_status = b[7];
      if (real_status) begin
         run_status = b;
      end else if (run_status == 8'd0) begin
         close_event(KIND_STOP, 4'd0, 8'd0, 8'd0, 24'd0, delta_acc, len - 1, 1'b1);
         return;
      end
      hi = run_status[7:4];
      if (hi == HI_NOTEOFF || hi == HI_NOTEON || hi == HI_CTRL || hi == HI_BEND) begin
         if (real_status) phase = PH_DATA1;
         else begin
            held_data = b;
            phase = PH_DATA2;
         end
      end else if (hi == HI_PROG) begin
         if (real_status) phase = PH_DATA1;
         else channel_done(KIND_PROG, b, 8'd0, 24'd0, len);
      end else if (run_status == STAT_META) begin
         if (real_status) phase = PH_META_TYPE;
         else meta_open(b);
      end else begin
         close_event(KIND_STOP, run_status[3:0], 8'd0, 8'd0, 24'd0, delta_acc,
                     real_status ? len : len - 1, 1'b1);
      end
   endtask

   task automatic data_pair(input logic [7:0] b, input logic [31:0] len);
      logic [3:0] kind;
      if (run_status[7:4] == HI_NOTEOFF) kind = KIND_NOTEOFF;
      else if (run_status[7:4] == HI_NOTEON) kind = (b != 0) ? KIND_NOTEON : KIND_NOTEOFF;
      else if (run_status[7:4] == HI_BEND) kind = KIND_BEND;
      else if (held_data == CC_VOLUME) kind = KIND_VOL;
      else if (held_data == CC_PAN) kind = KIND_PAN;
      else if (held_data == CC_EXPR) kind = KIND_EXPR;
      else if (held_data == CC_LOOP && b == LOOP_START) kind = KIND_LOOPSTART;
      else if (held_data == CC_LOOP && b == LOOP_END) kind = KIND_LOOPEND;
      else kind = KIND_CTRL;
      channel_done(kind, held_data, b, 24'd0, len);
   endtask

   // one accepted byte through the parse machine
   task automatic track_byte(input logic [7:0] b, input logic fin);
      logic [31:0] pos, len;
      record_type r;
      if (halted) return;
      rec_valid = 1'b0;
      pos = byte_pos;
      byte_pos = pos + 1;
      if (phase == PH_START) start_pos = pos;
      len = pos + 1 - start_pos;
      case (phase)
         PH_START: begin
            delta_acc = '0;
            varlen_count = '0;
            if (b == STAT_META && VARLEN_MAX_BYTES >= 2) begin
               delta_acc = 28'h7F;
               varlen_count = 3'd1;
               phase = PH_SAW_FF;
            end else begin
               delta_step(b);
            end
         end
         PH_SAW_FF: begin
            if (b == META_EOT) begin
               delta_acc = (28'h7F << 7) | 28'h2F;
               varlen_count = 3'd2;
               phase = PH_SAW_FF2F;
            end else begin
               delta_step(b);
            end
         end
         PH_SAW_FF2F: begin
            if (b == 8'd0) begin
               close_event(KIND_EOT, run_status[3:0], 8'd0, 8'd0, 24'd0, 28'd0, len, 1'b1);
            end else begin
               abs_time += 32'(delta_acc);
               status_position(b, len);
            end
         end
         PH_DELTA:     delta_step(b);
         PH_STATUS:    status_position(b, len);
         PH_DATA1: begin
            if (run_status[7:4] == HI_PROG) channel_done(KIND_PROG, b, 8'd0, 24'd0, len);
            else begin
               held_data = b;
               phase = PH_DATA2;
            end
         end
         PH_DATA2:     data_pair(b, len);
         PH_META_TYPE: meta_open(b);
         PH_META_LEN: begin
            meta_len = (meta_len << 7) | b[6:0];
            varlen_count++;
            if (!b[7] || varlen_count >= VARLEN_MAX_BYTES) begin
               if (meta_len == 0) meta_close(len);
               else phase = PH_META_BODY;
            end
         end
         PH_META_BODY: begin
            if (meta_seen == 0) meta_data[23:16] = b;
            else if (meta_seen == 1) meta_data[15:8] = b;
            else if (meta_seen == 2) meta_data[7:0] = b;
            meta_seen++;
            if (meta_seen >= meta_len) meta_close(len);
         end
         default: phase = PH_START;
      endcase
      // last byte of the file ends parsing either way
      if (fin && !halted) begin
         if (rec_valid) begin
            rec_stop = 1'b1;
            halted = 1'b1;
         end else begin
            close_event(KIND_TRUNC, 4'd0, 8'd0, 8'd0, 24'd0, delta_acc, len, 1'b1);
         end
      end
      if (rec_valid) begin
         r.event_kind = rec_kind;     r.midi_channel = rec_chan;
         r.first_data = rec_d1;       r.second_data = rec_d2;
         r.tempo_value = rec_tempo;   r.delta_ticks = rec_delta;
         r.event_time = abs_time;     r.event_start = start_pos;
         r.event_length = rec_len;    r.parsing_stopped = rec_stop;
         expected_records.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t checker: record %0d %s got 0x%0h expected 0x%0h",
               $realtime, record_count, field, got, want);
      error_count++;
   endtask

   // compare one record transfer with the oldest expected record
   task automatic check_record();
      record_type e;
      if (expected_records.size() == 0) begin
         $display("%0t checker: record with nothing expected", $realtime);
         error_count++;
         return;
      end
      e = expected_records.pop_front();
      if (rsp_tdata[3:0] !== e.event_kind)
         report_mismatch("event_kind", 32'(rsp_tdata[3:0]), 32'(e.event_kind));
      if (rsp_tdata[7:4] !== e.midi_channel)
         report_mismatch("midi_channel", 32'(rsp_tdata[7:4]), 32'(e.midi_channel));
      if (rsp_tdata[15:8] !== e.first_data)
         report_mismatch("first_data", 32'(rsp_tdata[15:8]), 32'(e.first_data));
      if (rsp_tdata[23:16] !== e.second_data)
         report_mismatch("second_data", 32'(rsp_tdata[23:16]), 32'(e.second_data));
      if (rsp_tdata[47:24] !== e.tempo_value)
         report_mismatch("tempo_value", 32'(rsp_tdata[47:24]), 32'(e.tempo_value));
      if (rsp_tdata[75:48] !== e.delta_ticks)
         report_mismatch("delta_ticks", 32'(rsp_tdata[75:48]), 32'(e.delta_ticks));
      if (rsp_tdata[107:76] !== e.event_time)
         report_mismatch("event_time", rsp_tdata[107:76], e.event_time);
      if (rsp_tdata[139:108] !== e.event_start)
         report_mismatch("event_start", rsp_tdata[139:108], e.event_start);
      if (rsp_tdata[171:140] !== e.event_length)
         report_mismatch("event_length", rsp_tdata[171:140], e.event_length);
      if (rsp_tdata[172] !== e.parsing_stopped)
         report_mismatch("parsing_stopped", 32'(rsp_tdata[172]), 32'(e.parsing_stopped));
   endtask

   initial begin
      error_count = 0;
      record_count = 0;
   end

   // sample both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         phase = PH_START; run_status = '0; delta_acc = '0; varlen_count = '0;
         abs_time = '0; held_data = '0; meta_kind = '0; meta_len = '0;
         meta_seen = '0; meta_data = '0; byte_pos = '0; start_pos = '0;
         halted = 1'b0; rec_valid = 1'b0;
         expected_records.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_record();
            record_count++;
         end
         if (req_tvalid && req_tready) track_byte(req_tdata, req_tuser);
      end
   end

endmodule

FILE: verif/midi_event_stream_parser_top_tb.sv
// ----------------------------------------------------------------------------
// midi_event_stream_parser_top_tb
// stream test of the event byte parser
// ----------------------------------------------------------------------------
// Builds one track of directed events (delta folding, note, controller, bend and
// program kinds, short and long meta payloads, running status) and then random
// well-formed events, closed by one randomly chosen way of ending the stream,
// followed by six bytes that must be ignored. Bytes go out under several idling
// phases and one long receiver hold-off; the checker predicts and compares records.
// ----------------------------------------------------------------------------
module midi_event_stream_parser_top_tb import mesp_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // [7:0] stream_byte
   logic         req_tuser;   // [0] final_byte
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [175:0] rsp_tdata;   // kind, channel, data, tempo, delta, time, start, length, stop
   int           error_count, pending, record_count;

   logic [7:0]   stream_bytes[$];
   bit           final_flags[$];
   logic [7:0]   last_status;
   int           ending_case;
   int           send_mode;
   bit           hold_request;

   midi_event_stream_parser_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   midi_event_stream_parser_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending(pending), .record_count(record_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic put_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
      final_flags.push_back(1'b0);
   endtask

   // variable-length delta, mostly one byte, never the end-of-track shortcut
   task automatic put_delta();
      int n;
      logic [7:0] b;
      n = ($urandom_range(99, 0) < 60) ? 1 : $urandom_range(4, 2);
      for (int i = 0; i < n; i++) begin
         if (i < n - 1) b = 8'h80 | 8'($urandom_range(127, 0));
         else if (n == 4) b = 8'($urandom_range(255, 0));
         else b = 8'($urandom_range(127, 0));
         if (i == 1 && stream_bytes[$] == STAT_META && b == META_EOT) b = 8'h2E;
         put_byte(b);
      end
   endtask

   task automatic put_meta_length(input logic [6:0] n);
      case ($urandom_range(5, 0))
         0: begin
            put_byte(8'h80);
            put_byte({1'b0, n});
         end
         1: begin
            // fourth byte ends the length whatever its top bit
            put_byte(8'h80); put_byte(8'h80); put_byte(8'h80);
            put_byte({1'b1, n});
         end
         default: put_byte({1'b0, n});
      endcase
   endtask

   task automatic put_meta_body(input logic [7:0] kind);
      logic [6:0] n;
      put_byte(kind);
      n = ($urandom_range(9, 0) == 0) ? 7'($urandom_range(12, 0)) : 7'($urandom_range(5, 0));
      put_meta_length(n);
      for (int i = 0; i < n; i++) put_byte(8'($urandom_range(255, 0)));
   endtask

   function automatic logic [7:0] pick_meta_kind();
      case ($urandom_range(3, 0))
         0: return META_TEMPO;
         1: return META_TIMESIG;
         default: begin
            logic [7:0] k;
            k = 8'($urandom_range(255, 0));
            return (k == META_EOT) ? 8'h01 : k;
         end
      endcase
   endfunction

   function automatic logic [7:0] pick_controller();
      case ($urandom_range(5, 0))
         0: return CC_VOLUME;
         1: return CC_PAN;
         2: return CC_EXPR;
         3, 4: return CC_LOOP;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // one random well-formed event, delta included
   task automatic put_event();
      logic [3:0] chan;
      logic [7:0] v;
      int pick;
      chan = 4'($urandom_range(15, 0));
      pick = $urandom_range(9, 0);
      if (pick >= 7 && last_status == 8'd0) pick = 0;
      put_delta();
      case (pick)
         0, 1: begin
            last_status = {HI_NOTEON, chan};
            put_byte(last_status);
            put_byte(8'($urandom_range(255, 0)));
            put_byte(($urandom_range(3, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 0)));
         end
         2, 4: begin
            last_status = {(pick == 2) ? HI_NOTEOFF : HI_BEND, chan};
            put_byte(last_status);
            put_byte(8'($urandom_range(255, 0)));
            put_byte(8'($urandom_range(255, 0)));
         end
         3: begin
            last_status = {HI_CTRL, chan};
            put_byte(last_status);
            put_byte(pick_controller());
            case ($urandom_range(2, 0))
               0: put_byte(LOOP_START);
               1: put_byte(LOOP_END);
               default: put_byte(8'($urandom_range(255, 0)));
            endcase
         end
         5: begin
            last_status = {HI_PROG, chan};
            put_byte(last_status);
            put_byte(8'($urandom_range(255, 0)));
         end
         6: begin
            last_status = STAT_META;
            put_byte(STAT_META);
            put_meta_body(pick_meta_kind());
         end
         default: begin
            // running status: first byte in status position is data
            if (last_status == STAT_META) begin
               v = pick_meta_kind();
               if (v[7]) v = 8'h03;
               put_meta_body(v);
            end else begin
               v = (last_status[7:4] == HI_CTRL) ? pick_controller()
                                                 : 8'($urandom_range(127, 0));
               if (v[7]) v = 8'h40;
               put_byte(v);
               if (last_status[7:4] != HI_PROG)
                  put_byte(($urandom_range(3, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 0)));
            end
         end
      endcase
   endtask

   // one of the ways a stream ends parsing
   task automatic put_ending();
      logic [7:0] s;
      ending_case = $urandom_range(5, 0);
      case (ending_case)
         0: put_event();
         1: begin
            put_delta();
            put_byte(8'h93);
            put_byte(8'h3C);
         end
         2: begin
            put_byte(STAT_META); put_byte(META_EOT); put_byte(8'd0);
         end
         3: begin
            put_delta();
            put_byte(STAT_META); put_byte(META_EOT); put_byte(8'd1); put_byte(8'h55);
         end
         4: begin
            put_delta();
            case ($urandom_range(2, 0))
               0: s = 8'hA0 | 8'($urandom_range(15, 0));
               1: s = 8'hD0 | 8'($urandom_range(15, 0));
               default: s = 8'($urandom_range(254, 240));
            endcase
            put_byte(s);
         end
         default: put_byte(8'h83);
      endcase
      // last byte of the file, except where a stop ends parsing first
      if (ending_case < 2 || ending_case == 5) final_flags[final_flags.size() - 1] = 1'b1;
      for (int i = 0; i < 6; i++) begin
         stream_bytes.push_back(8'($urandom_range(255, 0)));
         final_flags.push_back(1'($urandom_range(1, 0)));
      end
   endtask

   task automatic build_stream();
      // delta folding: FF then a non-2F byte, and FF 2F then a status byte
      put_byte(STAT_META); put_byte(8'h05); put_byte(8'h90); put_byte(8'h3C); put_byte(8'h00);
      put_byte(STAT_META); put_byte(META_EOT); put_byte(8'h91); put_byte(8'hFF);
      put_byte(8'h7F);
      // longest delta, then volume, pan, expression and both loop controllers
      put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
      put_byte(8'hBF); put_byte(CC_VOLUME); put_byte(8'h64);
      put_byte(8'h00); put_byte(CC_PAN); put_byte(8'h40);
      put_byte(8'h00); put_byte(CC_EXPR); put_byte(8'h7F);
      put_byte(8'h00); put_byte(CC_LOOP); put_byte(LOOP_START);
      put_byte(8'h00); put_byte(CC_LOOP); put_byte(LOOP_END);
      put_byte(8'h00); put_byte(8'h80); put_byte(8'hFF); put_byte(8'h80);
      put_byte(8'h00); put_byte(8'hE2); put_byte(8'h00); put_byte(8'h40);
      put_byte(8'h00); put_byte(8'hCA); put_byte(8'h85);
      put_byte(8'h00); put_byte(8'h11);
      // tempo full and short, time signature long and short, empty and long meta
      put_byte(8'h00); put_byte(STAT_META); put_byte(META_TEMPO); put_byte(8'h03);
      put_byte(8'h07); put_byte(8'hA1); put_byte(8'h20);
      put_byte(8'h00); put_byte(STAT_META); put_byte(META_TEMPO); put_byte(8'h02);
      put_byte(8'hFF); put_byte(8'hEE);
      put_byte(8'h00); put_byte(STAT_META); put_byte(META_TIMESIG); put_byte(8'h04);
      put_byte(8'h04); put_byte(8'h02); put_byte(8'h18); put_byte(8'h08);
      put_byte(8'h00); put_byte(STAT_META); put_byte(META_TIMESIG); put_byte(8'h01);
      put_byte(8'h06);
      put_byte(8'h00); put_byte(STAT_META); put_byte(8'h01); put_byte(8'h00);
      put_byte(8'h00); put_byte(STAT_META); put_byte(8'h7F); put_byte(8'h81); put_byte(8'h00);
      for (int i = 0; i < 128; i++) put_byte(8'(i * 2 + 1));
      last_status = STAT_META;
      while (stream_bytes.size() < 1440) put_event();
      put_ending();
   endtask

   // receiver: random stalls by phase, plus one long hold-off
   initial begin
      int hold_left;
      int stall_pct;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left = 400;
            hold_request = 1'b0;
         end
         stall_pct = (send_mode == 2) ? 74 : (send_mode == 3) ? 29 : 0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int idx, total, idle_pct, wait_cycles;
      send_mode = 0;
      hold_request = 1'b0;
      last_status = 8'd0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'd0;
      req_tuser <= 1'b0;
      build_stream();
      total = stream_bytes.size();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      idx = 0;
      while (idx < total) begin
         @(posedge clock);
         if (req_tvalid && req_tready) idx++;
         send_mode = (idx * 4) / total;
         if (idx == total / 8) hold_request = 1'b1;
         idle_pct = (send_mode == 1) ? 74 : (send_mode == 3) ? 29 : 0;
         if (idx < total && (!req_tvalid || (req_tvalid && req_tready))) begin
            if ($urandom_range(99, 0) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= stream_bytes[idx];
               req_tuser <= final_flags[idx];
            end else begin
               req_tvalid <= 1'b0;
            end
         end else if (idx >= total) begin
            req_tvalid <= 1'b0;
         end
      end
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      $display("run: %0d stream bytes sent, %0d records checked", total, record_count);
      $display("run: stream closed by ending case %0d, %0d records left over",
               ending_case, pending);
      if (error_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3ms;
      $display("tb: failure");
      $finish;
   end

endmodule
